// File: rtl/ipv4p_pkg.sv
// ipv4p_pkg: shared types for the ipv4 dotted address parser
package ipv4p_pkg;

  // one character beat as held in the input stage
  typedef struct packed {
    logic [7:0] char_in;
    logic       is_last;
  } char_beat_t;

  // one result beat as held in the output stage
  typedef struct packed {
    logic        ok;
    logic [31:0] address;
  } res_beat_t;

  // parser phase, one-hot
  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_ZERO   = 5'b00010,
    PH_DIGITS = 5'b00100,
    PH_DONE   = 5'b01000,
    PH_ERROR  = 5'b10000
  } phase_t;

  // radix of the current part
  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2
  } radix_t;

endpackage

// File: rtl/ipv4p_char_if.sv
// ipv4p_char_if: character channel with valid/ready handshake
interface ipv4p_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_last;

  modport source (output valid, output char_in, output is_last, input ready);
  modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

// ipv4p_res_if: result channel with valid/ready handshake
interface ipv4p_res_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] address;

  modport source (output valid, output ok, output address, input ready);
  modport sink   (input valid, input ok, input address, output ready);
endinterface

// File: rtl/ipv4p_in_stage.sv
// ipv4p_in_stage: input register that holds one character beat
module ipv4p_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  ipv4p_char_if.sink           chars,
  input  logic                 take,
  output logic                 item_valid,
  output ipv4p_pkg::char_beat_t item
);

  logic                  valid_q;
  ipv4p_pkg::char_beat_t data_q;

  // room when empty or when the held beat leaves this cycle
  assign chars.ready = !rst && (!valid_q || take);

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (chars.ready) begin
      valid_q <= chars.valid;
    end
  end

  // payload, loaded on each accepted beat
  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      data_q.char_in <= chars.char_in;
      data_q.is_last <= chars.is_last;
    end
  end

  assign item_valid = valid_q;
  assign item       = data_q;

endmodule

// File: rtl/ipv4p_parse.sv
// ipv4p_parse: per-character parser state and its registered update
module ipv4p_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  ipv4p_pkg::char_beat_t item,
  input  logic                  out_free,
  output logic                  take,
  output logic                  res_valid,
  output ipv4p_pkg::res_beat_t  res
);

  localparam logic [7:0] ASC_0   = 8'h30;
  localparam logic [7:0] ASC_1   = 8'h31;
  localparam logic [7:0] ASC_7   = 8'h37;
  localparam logic [7:0] ASC_9   = 8'h39;
  localparam logic [7:0] ASC_LA  = 8'h61;
  localparam logic [7:0] ASC_LF  = 8'h66;
  localparam logic [7:0] ASC_UA  = 8'h41;
  localparam logic [7:0] ASC_UF  = 8'h46;
  localparam logic [7:0] ASC_LX  = 8'h78;
  localparam logic [7:0] ASC_UX  = 8'h58;
  localparam logic [7:0] ASC_DOT = 8'h2e;
  localparam logic [7:0] ASC_SP  = 8'h20;
  localparam logic [7:0] ASC_NUL = 8'h00;
  localparam logic [7:0] ASC_TAB = 8'h09;
  localparam logic [7:0] ASC_CR  = 8'h0d;
  localparam logic [7:0] LOWER_OFS = 8'h57;
  localparam logic [7:0] UPPER_OFS = 8'h37;
  localparam logic [4:0] NO_DIGIT  = 5'd16;

  typedef struct packed {
    ipv4p_pkg::phase_t phase;
    ipv4p_pkg::radix_t radix;
    logic [31:0]       part_value;
    logic              saw_digit;
    logic [1:0]        part_count;
    logic [23:0]       leading_bytes;
  } pstate_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] addr;
  } fin_t;

  // digit value in the given radix, NO_DIGIT when not a digit
  function automatic logic [4:0] digit_of(input logic [7:0] c, input ipv4p_pkg::radix_t rx);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c >= ASC_0 && c <= ASC_9) begin
      d = {1'b0, c[3:0]};
    end else if (c >= ASC_LA && c <= ASC_LF) begin
      d = 5'(c - LOWER_OFS);
    end else if (c >= ASC_UA && c <= ASC_UF) begin
      d = 5'(c - UPPER_OFS);
    end
    if (rx == ipv4p_pkg::RX_OCT && d > 5'(ASC_7 - ASC_0)) begin
      d = NO_DIGIT;
    end
    if (rx == ipv4p_pkg::RX_DEC && d > 5'(ASC_9 - ASC_0)) begin
      d = NO_DIGIT;
    end
    return d;
  endfunction

  // nul or ascii whitespace
  function automatic logic is_term(input logic [7:0] c);
    return c == ASC_NUL || c == ASC_SP || (c >= ASC_TAB && c <= ASC_CR);
  endfunction

  // close the final part: range check against remaining bytes, then pack
  function automatic fin_t finish(input pstate_t s);
    fin_t f;
    logic fits;
    fits = 1'b1;
    f.addr = s.part_value;
    unique case (s.part_count)
      2'd0: begin
        fits = 1'b1;
      end
      2'd1: begin
        fits   = s.part_value[31:24] == 8'h00;
        f.addr = s.part_value | {s.leading_bytes[7:0], 24'h000000};
      end
      2'd2: begin
        fits   = s.part_value[31:16] == 16'h0000;
        f.addr = s.part_value | {s.leading_bytes[15:0], 16'h0000};
      end
      2'd3: begin
        fits   = s.part_value[31:8] == 24'h000000;
        f.addr = s.part_value | {s.leading_bytes, 8'h00};
      end
      default: begin
        fits = 1'b0;
      end
    endcase
    f.ok = s.saw_digit && fits;
    return f;
  endfunction

  localparam pstate_t RESET_STATE = '{
    phase:         ipv4p_pkg::PH_START,
    radix:         ipv4p_pkg::RX_DEC,
    part_value:    32'h0,
    saw_digit:     1'b0,
    part_count:    2'd0,
    leading_bytes: 24'h0
  };

  pstate_t     st;
  pstate_t     st_step;
  pstate_t     st_next;
  logic [7:0]  c;
  logic [4:0]  d;
  logic [35:0] acc;
  fin_t        fin_term;
  fin_t        fin_last;
  logic        digit_path;

  assign c = item.char_in;
  assign take      = item_valid && (!item.is_last || out_free);
  assign res_valid = take && item.is_last;

  // digit value and shift-add for the current radix
  always_comb begin
    d = digit_of(c, st.radix);
    unique case (st.radix)
      ipv4p_pkg::RX_DEC: acc = ({4'h0, st.part_value} << 3) + ({4'h0, st.part_value} << 1)
                               + {31'h0, d};
      ipv4p_pkg::RX_OCT: acc = ({4'h0, st.part_value} << 3) + {31'h0, d};
      ipv4p_pkg::RX_HEX: acc = ({4'h0, st.part_value} << 4) + {31'h0, d};
      default:           acc = {4'h0, st.part_value};
    endcase
  end

  assign fin_term = finish(st);

  // character step
  always_comb begin
    st_step    = st;
    digit_path = 1'b0;
    unique case (st.phase)
      ipv4p_pkg::PH_START: begin
        if (c == ASC_0) begin
          st_step.radix      = ipv4p_pkg::RX_OCT;
          st_step.part_value = 32'h0;
          st_step.saw_digit  = 1'b1;
          st_step.phase      = ipv4p_pkg::PH_ZERO;
        end else if (c >= ASC_1 && c <= ASC_9) begin
          st_step.radix      = ipv4p_pkg::RX_DEC;
          st_step.part_value = {28'h0, c[3:0]};
          st_step.saw_digit  = 1'b1;
          st_step.phase      = ipv4p_pkg::PH_DIGITS;
        end else begin
          st_step.phase = ipv4p_pkg::PH_ERROR;
        end
      end
      ipv4p_pkg::PH_ZERO: begin
        if (c == ASC_LX || c == ASC_UX) begin
          st_step.radix     = ipv4p_pkg::RX_HEX;
          st_step.saw_digit = 1'b0;
          st_step.phase     = ipv4p_pkg::PH_DIGITS;
        end else begin
          digit_path = 1'b1;
        end
      end
      ipv4p_pkg::PH_DIGITS: begin
        digit_path = 1'b1;
      end
      ipv4p_pkg::PH_DONE, ipv4p_pkg::PH_ERROR: begin
        st_step = st;
      end
      default: begin
        st_step.phase = ipv4p_pkg::PH_ERROR;
      end
    endcase

    if (digit_path) begin
      priority if (d != NO_DIGIT) begin
        if (acc[35:32] != 4'h0) begin
          st_step.phase = ipv4p_pkg::PH_ERROR;
        end else begin
          st_step.part_value = acc[31:0];
          st_step.saw_digit  = 1'b1;
          st_step.phase      = ipv4p_pkg::PH_DIGITS;
        end
      end else if (c == ASC_DOT) begin
        if (st.part_count == 2'd3 || st.part_value[31:8] != 24'h0) begin
          st_step.phase = ipv4p_pkg::PH_ERROR;
        end else begin
          st_step.leading_bytes = {st.leading_bytes[15:0], st.part_value[7:0]};
          st_step.part_count    = st.part_count + 2'd1;
          st_step.part_value    = 32'h0;
          st_step.saw_digit     = 1'b0;
          st_step.radix         = ipv4p_pkg::RX_DEC;
          st_step.phase         = ipv4p_pkg::PH_START;
        end
      end else if (is_term(c)) begin
        if (fin_term.ok) begin
          st_step.part_value = fin_term.addr;
          st_step.phase      = ipv4p_pkg::PH_DONE;
        end else begin
          st_step.phase = ipv4p_pkg::PH_ERROR;
        end
      end else begin
        st_step.phase = ipv4p_pkg::PH_ERROR;
      end
    end
  end

  assign fin_last = finish(st_step);

  // result on the last beat of a string
  always_comb begin
    res.ok      = 1'b0;
    res.address = 32'h0;
    unique case (st_step.phase)
      ipv4p_pkg::PH_ZERO, ipv4p_pkg::PH_DIGITS: begin
        res.ok      = fin_last.ok;
        res.address = fin_last.ok ? fin_last.addr : 32'h0;
      end
      ipv4p_pkg::PH_DONE: begin
        res.ok      = 1'b1;
        res.address = st_step.part_value;
      end
      ipv4p_pkg::PH_START, ipv4p_pkg::PH_ERROR: begin
        res.ok      = 1'b0;
        res.address = 32'h0;
      end
      default: begin
        res.ok      = 1'b0;
        res.address = 32'h0;
      end
    endcase
  end

  // state returns to its reset value after each string
  assign st_next = item.is_last ? RESET_STATE : st_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= RESET_STATE;
    end else if (take) begin
      st <= st_next;
    end
  end

endmodule

// File: rtl/ipv4p_out_stage.sv
// ipv4p_out_stage: result register driving the result channel
module ipv4p_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  ipv4p_pkg::res_beat_t res_d,
  output logic                 free,
  ipv4p_res_if.source          result
);

  logic                 valid_q;
  ipv4p_pkg::res_beat_t data_q;

  // free when empty or when the held beat is taken this cycle
  assign free = !valid_q || result.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (result.ready) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_q <= res_d;
    end
  end

  assign result.valid   = valid_q;
  assign result.ok      = data_q.ok;
  assign result.address = data_q.address;

endmodule

// File: rtl/ipv4_dotted_address_parser_core.sv
// ipv4_dotted_address_parser_core: top level of the streaming ipv4 address parser
//
//   channel  dir  payload                     beat
//   chars    in   char_in[7:0], is_last       one character of the string
//   result   out  ok, address[31:0]           one per string, on is_last
//
// one character per cycle sustained, but the output register stalls last-character
// beats while full; other beats keep flowing while a result waits. a beat is held
// in the input register, and the parser state and result register are updated
// when the parser takes it. reset (rst, synchronous) clears the valid flags and
// the parser state; the payload registers are not reset.
module ipv4_dotted_address_parser_core (
  input  logic        clk,
  input  logic        rst,
  ipv4p_char_if.sink  chars,
  ipv4p_res_if.source result
);

  logic                  item_valid;
  ipv4p_pkg::char_beat_t item;
  logic                  take;
  logic                  out_free;
  logic                  res_valid;
  ipv4p_pkg::res_beat_t  res;

  ipv4p_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  ipv4p_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  ipv4p_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (res_valid),
    .res_d  (res),
    .free   (out_free),
    .result (result)
  );

endmodule

// File: rtl/ipv4p_checker.sv
// ipv4p_checker: port-level assertions for the parser core, with bind
module ipv4p_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_ok,
  input logic [31:0] out_address
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // a newly raised result traces back to an accepted last beat
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(rst, 2) && $rose(out_valid)
      |-> $past(in_valid && in_ready && in_last, 2))
    else $error("result without a last beat");

  // a rejected string reports address zero
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ok |-> out_address == 32'h0)
    else $error("rejected result with nonzero address");

  // input never stalls while the output is empty
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind ipv4_dotted_address_parser_core ipv4p_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (chars.valid),
  .in_ready    (chars.ready),
  .in_last     (chars.is_last),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_ok      (result.ok),
  .out_address (result.address)
);

// File: bench/ipv4_dotted_address_parser_core_test.sv
// ipv4_dotted_address_parser_core_test: self-checking bench for the streaming ipv4 address parser
`timescale 1ns / 100ps

module ipv4_dotted_address_parser_core_test;

  localparam int N_DIRECTED  = 13;
  localparam int RANDOM_CHARS = 750;
  localparam int HOLD_CYCLES = 150;
  localparam int IDLE_LIMIT  = 2000;

  // expected outcome of a directed row: typed in, or left to the parser model
  typedef struct packed {
    logic        typed;
    logic        ok;
    logic [31:0] address;
  } want_t;

  localparam want_t REJECT   = {1'b1, 1'b0, 32'h0000_0000};
  localparam want_t BY_MODEL = {1'b0, 1'b0, 32'h0000_0000};

  logic clk = 1'b0;
  logic rst = 1'b1;

  ipv4p_char_if char_ch ();
  ipv4p_res_if  result_ch ();

  ipv4_dotted_address_parser_core dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (char_ch),
    .result (result_ch)
  );

  // clock
  always #4 clk = ~clk;

  // parser model state
  ipv4p_pkg::phase_t cur_phase;
  ipv4p_pkg::radix_t cur_radix;
  logic [31:0]       cur_part;
  logic              cur_has_digit;
  logic [1:0]        done_parts;
  logic [23:0]       lead_bytes;

  // addresses still to come out of the block, oldest first
  ipv4p_pkg::res_beat_t expected_addrs[$];

  int  mismatches    = 0;
  int  strings_sent  = 0;
  int  chars_sent    = 0;
  int  results_seen  = 0;
  int  rejects_seen  = 0;
  int  idle_cycles   = 0;
  bit  calm          = 1'b0;
  bit  hold_off      = 1'b0;
  bit  random_phase  = 1'b0;

  // directed rows; '@' stands for a NUL character
  string dir_text [N_DIRECTED] = '{
    "@", "0", "0x.9", "0X", "09", "256.1", "1.256", "a", "7 z", "7@q", "7z", "\377",
    "0xFFFFFFFF"
  };
  want_t dir_want [N_DIRECTED] = '{
    REJECT,
    {1'b1, 1'b1, 32'h0000_0000},
    {1'b1, 1'b1, 32'h0000_0009},
    REJECT,
    REJECT,
    REJECT,
    {1'b1, 1'b1, 32'h0100_0100},
    REJECT,
    BY_MODEL,
    BY_MODEL,
    REJECT,
    REJECT,
    {1'b1, 1'b1, 32'hffff_ffff}
  };

  function automatic void reset_parser();
    cur_phase     = ipv4p_pkg::PH_START;
    cur_radix     = ipv4p_pkg::RX_DEC;
    cur_part      = '0;
    cur_has_digit = 1'b0;
    done_parts    = '0;
    lead_bytes    = '0;
  endfunction

  // close the final part: check it fits the bytes left and merge the leading ones
  function automatic void close_part();
    logic [31:0] ceiling;
    if (!cur_has_digit) begin
      cur_phase = ipv4p_pkg::PH_ERROR;
      return;
    end
    case (done_parts)
      2'd1:    ceiling = 32'h00ff_ffff;
      2'd2:    ceiling = 32'h0000_ffff;
      2'd3:    ceiling = 32'h0000_00ff;
      default: ceiling = 32'hffff_ffff;
    endcase
    if (cur_part > ceiling) begin
      cur_phase = ipv4p_pkg::PH_ERROR;
      return;
    end
    if (done_parts != 2'd0)
      cur_part = cur_part | ({8'h00, lead_bytes} << (8 * (4 - done_parts)));
    cur_phase = ipv4p_pkg::PH_DONE;
  endfunction

  // advance the parser model by one character; returns 1 when a result is due
  function automatic bit parse_char(input logic [7:0] c, input bit last,
                                    output ipv4p_pkg::res_beat_t res);
    logic [4:0]  d;
    logic [63:0] grown;
    logic [63:0] base;
    bit          stop;
    res  = '0;
    stop = (c == 8'h00) || (c == " ") || (c >= 8'h09 && c <= 8'h0d);
    case (cur_phase)
      ipv4p_pkg::PH_START: begin
        if (c == "0") begin
          cur_radix = ipv4p_pkg::RX_OCT; cur_part = '0; cur_has_digit = 1'b1;
          cur_phase = ipv4p_pkg::PH_ZERO;
        end else if (c >= "1" && c <= "9") begin
          cur_radix = ipv4p_pkg::RX_DEC; cur_part = 32'(c - "0"); cur_has_digit = 1'b1;
          cur_phase = ipv4p_pkg::PH_DIGITS;
        end else begin
          cur_phase = ipv4p_pkg::PH_ERROR;
        end
      end
      ipv4p_pkg::PH_ZERO, ipv4p_pkg::PH_DIGITS: begin
        if (cur_phase == ipv4p_pkg::PH_ZERO && (c == "x" || c == "X")) begin
          cur_radix = ipv4p_pkg::RX_HEX; cur_has_digit = 1'b0;
          cur_phase = ipv4p_pkg::PH_DIGITS;
        end else begin
          // digit value in the current radix, 16 when not a digit
          d = 5'd16;
          if (c >= "0" && c <= "9") d = 5'(c - "0");
          else if (c >= "a" && c <= "f") d = 5'(c - "a" + 10);
          else if (c >= "A" && c <= "F") d = 5'(c - "A" + 10);
          if ((cur_radix == ipv4p_pkg::RX_OCT && d > 5'd7) ||
              (cur_radix == ipv4p_pkg::RX_DEC && d > 5'd9))
            d = 5'd16;
          base = (cur_radix == ipv4p_pkg::RX_HEX) ? 64'd16 :
                 (cur_radix == ipv4p_pkg::RX_OCT) ? 64'd8 : 64'd10;
          if (d < 5'd16) begin
            grown = {32'h0, cur_part} * base + 64'(d);
            if (grown > 64'h0000_0000_ffff_ffff) begin
              cur_phase = ipv4p_pkg::PH_ERROR;
            end else begin
              cur_part = grown[31:0]; cur_has_digit = 1'b1;
              cur_phase = ipv4p_pkg::PH_DIGITS;
            end
          end else if (c == ".") begin
            // a dot closes a leading part of one byte
            if (done_parts == 2'd3 || cur_part > 32'h0000_00ff) begin
              cur_phase = ipv4p_pkg::PH_ERROR;
            end else begin
              lead_bytes    = {lead_bytes[15:0], cur_part[7:0]};
              done_parts    = done_parts + 2'd1;
              cur_part      = '0;
              cur_has_digit = 1'b0;
              cur_radix     = ipv4p_pkg::RX_DEC;
              cur_phase     = ipv4p_pkg::PH_START;
            end
          end else if (stop) begin
            close_part();
          end else begin
            cur_phase = ipv4p_pkg::PH_ERROR;
          end
        end
      end
      default: ;
    endcase
    if (!last) return 1'b0;
    // end of string closes whatever part is open
    if (cur_phase == ipv4p_pkg::PH_START) cur_phase = ipv4p_pkg::PH_ERROR;
    else if (cur_phase == ipv4p_pkg::PH_ZERO || cur_phase == ipv4p_pkg::PH_DIGITS)
      close_part();
    if (cur_phase == ipv4p_pkg::PH_DONE) begin
      res.ok      = 1'b1;
      res.address = cur_part;
    end
    reset_parser();
    return 1'b1;
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  // drive one character beat and record the result it will cause
  task automatic send_char(input logic [7:0] c, input bit last, input want_t want);
    int                   gap;
    ipv4p_pkg::res_beat_t res;
    gap = draw_wait();
    if (gap > 0) begin
      char_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_ch.char_in <= c;
    char_ch.is_last <= last;
    char_ch.valid   <= 1'b1;
    do @(posedge clk); while (!char_ch.ready);
    chars_sent++;
    if (parse_char(c, last, res)) begin
      if (want.typed) res = {want.ok, want.address};
      expected_addrs.push_back(res);
    end
    @(negedge clk);
  endtask

  task automatic send_string(ref logic [7:0] s[$], input want_t want);
    for (int i = 0; i < s.size(); i++)
      send_char(s[i], i == s.size() - 1, want);
    strings_sent++;
  endtask

  // mostly well-formed dotted strings with random radix and value, plus noise
  task automatic make_string(ref logic [7:0] s[$]);
    int                n_parts;
    int                base;
    int                pos;
    logic [31:0]       v;
    logic [7:0]        dgt;
    logic [7:0]        hex_base;
    logic [7:0]        tmp[$];
    ipv4p_pkg::radix_t rx;
    s.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n_parts = ($urandom_range(0, 15) == 0) ? 5 : $urandom_range(1, 4);
    for (int p = 0; p < n_parts; p++) begin
      if (p > 0) s.push_back(".");
      if (p == n_parts - 1) begin
        case ($urandom_range(0, 3))
          0:       v = $urandom;
          1:       v = $urandom_range(0, 32'hff);
          2:       v = $urandom_range(0, 32'hffff);
          default: v = $urandom_range(0, 32'hff_ffff);
        endcase
      end else begin
        v = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 1000) : $urandom_range(0, 255);
      end
      rx       = ipv4p_pkg::radix_t'($urandom_range(0, 2));
      base     = (rx == ipv4p_pkg::RX_HEX) ? 16 : (rx == ipv4p_pkg::RX_OCT) ? 8 : 10;
      hex_base = $urandom_range(0, 1) ? "A" : "a";
      // radix prefix
      if (rx == ipv4p_pkg::RX_OCT || (rx == ipv4p_pkg::RX_DEC && v == 0)) begin
        s.push_back("0");
      end else if (rx == ipv4p_pkg::RX_HEX) begin
        s.push_back("0");
        s.push_back($urandom_range(0, 1) ? "x" : "X");
        if (v == 0 && $urandom_range(0, 1)) s.push_back("0");
      end
      tmp.delete();
      while (v != 0) begin
        dgt = 8'(v % base);
        tmp.push_front(dgt < 10 ? 8'("0" + dgt) : 8'(hex_base + dgt - 10));
        v = v / base;
      end
      foreach (tmp[k]) s.push_back(tmp[k]);
    end
    // extra digits push the last part toward overflow
    if ($urandom_range(0, 11) == 0) repeat ($urandom_range(1, 3)) s.push_back("9");
    // terminator followed by junk that must be ignored
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 6))
        0:       s.push_back(8'h00);
        1:       s.push_back(" ");
        default: s.push_back(8'($urandom_range(9, 13)));
      endcase
      repeat ($urandom_range(0, 3)) s.push_back(8'($urandom_range(0, 255)));
    end
    // break one character now and then
    if ($urandom_range(0, 4) == 0) begin
      pos = $urandom_range(0, s.size() - 1);
      case ($urandom_range(0, 3))
        0:       s[pos] = 8'("0" + $urandom_range(0, 9));
        1:       s[pos] = ".";
        2:       s[pos] = "x";
        default: s[pos] = 8'($urandom_range(0, 255));
      endcase
    end
  endtask

  // stretches of back-to-back traffic on both sides
  initial begin
    forever begin
      repeat ($urandom_range(30, 150)) @(posedge clk);
      calm = ($urandom_range(0, 3) == 0);
    end
  end

  // one long receiver hold-off so the block backs up into the input
  initial begin
    wait (random_phase);
    repeat ($urandom_range(50, 200)) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // result side: random stalls, compare every beat with the oldest expectation
  initial begin
    int                   stall;
    ipv4p_pkg::res_beat_t want;
    ipv4p_pkg::res_beat_t got;
    result_ch.ready = 1'b0;
    stall = draw_wait();
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off || stall > 0) begin
        result_ch.ready <= 1'b0;
        if (!hold_off) stall--;
      end else begin
        result_ch.ready <= 1'b1;
      end
      @(posedge clk);
      if (result_ch.valid && result_ch.ready) begin
        got.ok      = result_ch.ok;
        got.address = result_ch.address;
        results_seen++;
        if (expected_addrs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: ok=%0b address=%h", got.ok, got.address);
        end else begin
          want = expected_addrs.pop_front();
          if (!want.ok) rejects_seen++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch: expected ok=%0b address=%h, got ok=%0b address=%h",
                       results_seen, want.ok, want.address, got.ok, got.address);
          end
        end
        stall = draw_wait();
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((char_ch.valid && char_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ipv4_dotted_address_parser_core test failed");
      $finish;
    end
  end

  // stimulus: directed rows, then random strings
  initial begin
    logic [7:0] s[$];
    int         random_chars;
    random_chars    = 0;
    char_ch.valid   = 1'b0;
    char_ch.char_in = 8'h00;
    char_ch.is_last = 1'b0;
    reset_parser();
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      s.delete();
      for (int j = 0; j < dir_text[i].len(); j++)
        s.push_back(dir_text[i][j] == "@" ? 8'h00 : dir_text[i][j]);
      send_string(s, dir_want[i]);
    end

    random_phase = 1'b1;
    while (random_chars < RANDOM_CHARS) begin
      make_string(s);
      send_string(s, BY_MODEL);
      random_chars += s.size();
    end
    char_ch.valid <= 1'b0;

    // drain, then wait for any stray beat
    while (expected_addrs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("parsed %0d strings in %0d character beats: %0d results, %0d rejected",
             strings_sent, chars_sent, results_seen, rejects_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0)
      $display("ipv4_dotted_address_parser_core test passed");
    else
      $display("ipv4_dotted_address_parser_core test failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/ipv4p_pkg.sv
rtl/ipv4p_char_if.sv
rtl/ipv4p_in_stage.sv
rtl/ipv4p_parse.sv
rtl/ipv4p_out_stage.sv
rtl/ipv4_dotted_address_parser_core.sv
rtl/ipv4p_checker.sv
bench/ipv4_dotted_address_parser_core_test.sv
